/* design/prr_pkg.sv */
`timescale 1ns / 1ps
// prr_pkg: shared types and constants for the polyphase rational resampler.
// No dependencies.
package prr_pkg;

	localparam int SAMPLE_BITS        = 24;
	localparam int COEF_BITS          = 24;
	localparam int COEF_DEPTH_DEF     = 16384;
	localparam int HISTORY_FRAMES_DEF = 2048;
	localparam int MAX_RESULTS        = 24;
	localparam int ACC_BITS           = 64;
	localparam int UP_BITS            = 16;
	localparam int DOWN_BITS          = 18;
	localparam int REACH_BITS         = 11;
	localparam int CHAN_BITS          = 2;
	localparam int TAP_BITS           = REACH_BITS + 1;
	localparam int COUNT_BITS         = 32;
	localparam int ADDR_BITS          = UP_BITS + TAP_BITS;
	localparam int IDX_BITS           = COUNT_BITS + 2;
	localparam int DIV_BITS           = DOWN_BITS + 1;
	localparam int CFG_DATA_BITS      = 18;
	localparam int CFG_INDEX_BITS     = 2;
	localparam int ROUND_SHIFT        = COEF_BITS - 2;

	typedef enum logic [1:0] {
		ACT_LOAD    = 2'd0,
		ACT_SAMPLE  = 2'd1,
		ACT_PAD     = 2'd2,
		ACT_RESTART = 2'd3
	} action_t;

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		REG_UP    = 2'd0,
		REG_DOWN  = 2'd1,
		REG_REACH = 2'd2,
		REG_CHAN  = 2'd3
	} cfg_reg_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CHECK,
		ST_START,
		ST_MAC,
		ST_DRAIN,
		ST_ROUND,
		ST_DIV,
		ST_UPDATE,
		ST_DECIDE,
		ST_PUSH
	} state_t;

endpackage

/* design/polyphase_rational_resampler.sv */
`timescale 1ns / 1ps
// polyphase_rational_resampler: top level, sequencer and shared MAC datapath.
// Depends on prr_pkg and prr_ram.
//
// Rational polyphase resampler, one or two channels. Load the phase-major
// coefficient table with load beats first. A sample or pad beat produces up
// to 24 output beats. For each output, one multiply-accumulate unit walks the
// taps, one per cycle, fed by the coefficient RAM and history RAM read ports,
// then a bit-serial divider advances the phase. The input is not ready until
// all output beats of a beat are handed to the output register. Frame counts
// and the history depth act as fill marks, so no clearing pass is needed after
// reset. COEF_DEPTH and HISTORY_FRAMES must be powers of two.
module polyphase_rational_resampler #(
	parameter int COEF_DEPTH     = prr_pkg::COEF_DEPTH_DEF,
	parameter int HISTORY_FRAMES = prr_pkg::HISTORY_FRAMES_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// coef_index[13:0], coef_value[37:14], sample_0[61:38], sample_1[85:62], zero pad
	input  logic [87:0]                         s_tdata,
	// action[1:0]
	input  logic [1:0]                          s_tuser,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// out_0[23:0], out_1[47:24]
	output logic [47:0]                         m_tdata,
	// clip_done[0]
	output logic                                m_tuser,
	output logic                                m_tlast,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [prr_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
	input  logic [prr_pkg::CFG_DATA_BITS-1:0]   cfg_data
);

	localparam int CAW = $clog2(COEF_DEPTH);
	localparam int HAW = $clog2(HISTORY_FRAMES);
	localparam int SB  = prr_pkg::SAMPLE_BITS;
	localparam int CB  = prr_pkg::COEF_BITS;
	localparam int PB  = SB + CB;
	localparam int AB  = prr_pkg::ACC_BITS;
	localparam int NB  = prr_pkg::COUNT_BITS;
	localparam int IB  = prr_pkg::IDX_BITS;
	localparam int RB  = AB - prr_pkg::ROUND_SHIFT;

	prr_pkg::state_t state_q, state_d;

	logic [prr_pkg::UP_BITS-1:0]    up_q;
	logic [prr_pkg::DOWN_BITS-1:0]  down_q;
	logic [prr_pkg::REACH_BITS-1:0] reach_q;
	logic [prr_pkg::CHAN_BITS-1:0]  chan_q;

	logic [NB-1:0] frames_q, real_q, base_q;
	logic [prr_pkg::UP_BITS-1:0] phase_q;
	logic padding_q, finished_q, pad_item_q, after_q, ch_q;
	logic [4:0] count_q;
	logic [1:0] drain_q;

	logic [prr_pkg::ADDR_BITS-1:0] addr_base_q, addr_q;
	logic [IB-1:0] idx_q;
	logic [prr_pkg::TAP_BITS-1:0] tap_q;
	logic v_s1, v_s2;
	logic signed [PB-1:0] prod_s2;
	logic [AB-1:0] acc_q;

	logic [prr_pkg::DIV_BITS-1:0] num_q, quo_q;
	logic [prr_pkg::UP_BITS-1:0] rem_q;
	logic [4:0] div_cnt_q;

	logic [SB-1:0] res0_q, res1_q;
	logic clip_q, last_q;
	logic [47:0] m_tdata_q;
	logic m_tvalid_q, m_tuser_q, m_tlast_q;

	// input unpack
	prr_pkg::action_t in_action;
	logic [13:0]   in_coef_index;
	logic [CB-1:0] in_coef_value;
	logic [SB-1:0] in_s0, in_s1;
	assign in_action     = prr_pkg::action_t'(s_tuser);
	assign in_coef_index = s_tdata[13:0];
	assign in_coef_value = s_tdata[37:14];
	assign in_s0         = s_tdata[61:38];
	assign in_s1         = s_tdata[85:62];

	logic s_acc;
	assign s_tready  = (state_q == prr_pkg::ST_IDLE);
	assign cfg_ready = (state_q == prr_pkg::ST_IDLE);
	assign s_acc     = s_tvalid && s_tready;

	// effective register values
	logic [prr_pkg::UP_BITS-1:0]    up_eff;
	logic [prr_pkg::DOWN_BITS-1:0]  down_eff;
	logic [prr_pkg::REACH_BITS-1:0] reach_eff;
	logic [prr_pkg::TAP_BITS-1:0]   taps;
	logic nch2, pass;
	assign up_eff    = (up_q == '0) ? prr_pkg::UP_BITS'(1) : up_q;
	assign down_eff  = (down_q == '0) ? prr_pkg::DOWN_BITS'(1) : down_q;
	assign reach_eff = (reach_q == '0) ? prr_pkg::REACH_BITS'(1) : reach_q;
	assign taps      = {reach_eff, 1'b0};
	assign nch2      = (chan_q >= prr_pkg::CHAN_BITS'(2));
	assign pass      = (prr_pkg::DOWN_BITS'(up_eff) == down_eff);

	logic [SB-1:0] s1_eff;
	assign s1_eff = nch2 ? in_s1 : '0;

	// emit condition
	logic [NB:0] base_reach;
	logic cond, base_lt_real;
	assign base_reach   = {1'b0, base_q} + (NB+1)'(reach_eff);
	assign base_lt_real = (base_q < real_q);
	assign cond = (count_q != 5'(prr_pkg::MAX_RESULTS)) && (base_reach < {1'b0, frames_q})
		&& (!pad_item_q || base_lt_real);

	// tap range
	logic inrange;
	assign inrange = !idx_q[IB-1] && (idx_q[IB-2:0] < {1'b0, real_q})
		&& (addr_q < prr_pkg::ADDR_BITS'(COEF_DEPTH));

	// memories
	logic coef_we, hist_we;
	logic [CB-1:0] coef_rd;
	logic [2*SB-1:0] hist_wd, hist_rd;
	logic [SB-1:0] hist_ch;
	assign coef_we = s_acc && (in_action == prr_pkg::ACT_LOAD)
		&& (32'(in_coef_index) < 32'(COEF_DEPTH));
	assign hist_we = s_acc && !finished_q
		&& (((in_action == prr_pkg::ACT_SAMPLE) && !padding_q)
		|| ((in_action == prr_pkg::ACT_PAD) && !pass));
	assign hist_wd = (in_action == prr_pkg::ACT_SAMPLE) ? {s1_eff, in_s0} : '0;
	assign hist_ch = ch_q ? hist_rd[2*SB-1:SB] : hist_rd[SB-1:0];

	prr_ram #(.WIDTH(CB), .DEPTH(COEF_DEPTH)) u_coef_ram (
		.clk   (clk),
		.we    (coef_we),
		.waddr (CAW'(in_coef_index)),
		.wdata (in_coef_value),
		.raddr (addr_q[CAW-1:0]),
		.rdata (coef_rd)
	);

	prr_ram #(.WIDTH(2*SB), .DEPTH(HISTORY_FRAMES)) u_hist_ram (
		.clk   (clk),
		.we    (hist_we),
		.waddr (frames_q[HAW-1:0]),
		.wdata (hist_wd),
		.raddr (idx_q[HAW-1:0]),
		.rdata (hist_rd)
	);

	// rounding and saturation
	logic [AB-1:0] rnd;
	logic [RB-1:0] sh;
	logic [SB-1:0] sat;
	assign rnd = acc_q + (AB'(1) << (prr_pkg::ROUND_SHIFT - 1));
	assign sh  = rnd[AB-1:prr_pkg::ROUND_SHIFT];
	always_comb begin
		if ((sh[RB-1:SB-1] == '0) || (sh[RB-1:SB-1] == '1)) begin
			sat = sh[SB-1:0];
		end else if (sh[RB-1]) begin
			sat = {1'b1, {(SB-1){1'b0}}};
		end else begin
			sat = {1'b0, {(SB-1){1'b1}}};
		end
	end

	// divider step
	logic [prr_pkg::UP_BITS:0] trial;
	logic trial_ge;
	assign trial    = {rem_q, num_q[prr_pkg::DIV_BITS-1]};
	assign trial_ge = (trial >= {1'b0, up_eff});

	logic [NB:0] base_sum;
	assign base_sum = {1'b0, base_q} + (NB+1)'(quo_q);

	logic out_free;
	assign out_free = !m_tvalid_q || m_tready;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			prr_pkg::ST_IDLE: begin
				if (s_acc) begin
					case (in_action)
						prr_pkg::ACT_SAMPLE: begin
							if (!padding_q && !finished_q) begin
								state_d = pass ? prr_pkg::ST_PUSH : prr_pkg::ST_CHECK;
							end
						end
						prr_pkg::ACT_PAD: begin
							if (!finished_q && !pass && base_lt_real) begin
								state_d = prr_pkg::ST_CHECK;
							end
						end
						default: state_d = prr_pkg::ST_IDLE;
					endcase
				end
			end
			prr_pkg::ST_CHECK:  state_d = cond ? prr_pkg::ST_START : prr_pkg::ST_IDLE;
			prr_pkg::ST_START:  state_d = prr_pkg::ST_MAC;
			prr_pkg::ST_MAC: begin
				if (tap_q == taps - prr_pkg::TAP_BITS'(1)) begin
					state_d = prr_pkg::ST_DRAIN;
				end
			end
			prr_pkg::ST_DRAIN: begin
				if (drain_q == 2'd1) begin
					state_d = prr_pkg::ST_ROUND;
				end
			end
			prr_pkg::ST_ROUND:  state_d = (!ch_q && nch2) ? prr_pkg::ST_START : prr_pkg::ST_DIV;
			prr_pkg::ST_DIV: begin
				if (div_cnt_q == 5'd1) begin
					state_d = prr_pkg::ST_UPDATE;
				end
			end
			prr_pkg::ST_UPDATE: state_d = prr_pkg::ST_DECIDE;
			prr_pkg::ST_DECIDE: state_d = prr_pkg::ST_PUSH;
			prr_pkg::ST_PUSH: begin
				if (out_free) begin
					state_d = after_q ? prr_pkg::ST_CHECK : prr_pkg::ST_IDLE;
				end
			end
			default: state_d = prr_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= prr_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			up_q       <= prr_pkg::UP_BITS'(1);
			down_q     <= prr_pkg::DOWN_BITS'(1);
			reach_q    <= prr_pkg::REACH_BITS'(34);
			chan_q     <= prr_pkg::CHAN_BITS'(1);
			frames_q   <= '0;
			real_q     <= '0;
			base_q     <= '0;
			phase_q    <= '0;
			padding_q  <= 1'b0;
			finished_q <= 1'b0;
			pad_item_q <= 1'b0;
			after_q    <= 1'b0;
			ch_q       <= 1'b0;
			count_q    <= '0;
			drain_q    <= '0;
			tap_q      <= '0;
			div_cnt_q  <= '0;
			v_s1       <= 1'b0;
			v_s2       <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (prr_pkg::cfg_reg_t'(cfg_index))
					prr_pkg::REG_UP:    up_q    <= cfg_data[prr_pkg::UP_BITS-1:0];
					prr_pkg::REG_DOWN:  down_q  <= cfg_data[prr_pkg::DOWN_BITS-1:0];
					prr_pkg::REG_REACH: reach_q <= cfg_data[prr_pkg::REACH_BITS-1:0];
					prr_pkg::REG_CHAN:  chan_q  <= cfg_data[prr_pkg::CHAN_BITS-1:0];
					default:            chan_q  <= chan_q;
				endcase
			end

			v_s1 <= (state_q == prr_pkg::ST_MAC) && inrange;
			v_s2 <= v_s1;

			if ((state_q == prr_pkg::ST_PUSH) && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end

			if (hist_we && (frames_q != '1)) begin
				frames_q <= frames_q + NB'(1);
			end

			case (state_q)
				prr_pkg::ST_IDLE: begin
					count_q <= '0;
					if (s_acc) begin
						case (in_action)
							prr_pkg::ACT_RESTART: begin
								frames_q   <= '0;
								real_q     <= '0;
								base_q     <= '0;
								phase_q    <= '0;
								padding_q  <= 1'b0;
								finished_q <= 1'b0;
							end
							prr_pkg::ACT_SAMPLE: begin
								pad_item_q <= 1'b0;
								after_q    <= 1'b0;
								if (!padding_q && !finished_q && (real_q != '1)) begin
									real_q <= real_q + NB'(1);
								end
							end
							prr_pkg::ACT_PAD: begin
								pad_item_q <= 1'b1;
								if (!finished_q) begin
									padding_q <= 1'b1;
									if (pass || !base_lt_real) begin
										finished_q <= 1'b1;
									end
								end
							end
							default: pad_item_q <= pad_item_q;
						endcase
					end
				end
				prr_pkg::ST_CHECK: ch_q <= 1'b0;
				prr_pkg::ST_START: tap_q <= '0;
				prr_pkg::ST_MAC: begin
					tap_q   <= tap_q + prr_pkg::TAP_BITS'(1);
					drain_q <= 2'd2;
				end
				prr_pkg::ST_DRAIN: drain_q <= drain_q - 2'd1;
				prr_pkg::ST_ROUND: begin
					ch_q      <= 1'b1;
					div_cnt_q <= 5'(prr_pkg::DIV_BITS);
				end
				prr_pkg::ST_DIV: div_cnt_q <= div_cnt_q - 5'd1;
				prr_pkg::ST_UPDATE: begin
					base_q  <= base_sum[NB] ? '1 : base_sum[NB-1:0];
					phase_q <= rem_q;
					count_q <= count_q + 5'd1;
				end
				prr_pkg::ST_DECIDE: begin
					after_q <= !(pad_item_q && !base_lt_real) && cond;
					if (pad_item_q && !base_lt_real) begin
						finished_q <= 1'b1;
					end
				end
				default: ch_q <= ch_q;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		prod_s2 <= $signed(coef_rd) * $signed(hist_ch);
		if (v_s2) begin
			acc_q <= acc_q + {{(AB-PB){prod_s2[PB-1]}}, prod_s2};
		end
		case (state_q)
			prr_pkg::ST_IDLE: begin
				res0_q <= in_s0;
				res1_q <= s1_eff;
				clip_q <= 1'b0;
				last_q <= 1'b1;
			end
			prr_pkg::ST_CHECK: begin
				addr_base_q <= prr_pkg::ADDR_BITS'(phase_q * taps);
				res1_q      <= '0;
			end
			prr_pkg::ST_START: begin
				addr_q <= addr_base_q;
				idx_q  <= IB'(base_q) - IB'(reach_eff) + IB'(1);
				acc_q  <= '0;
			end
			prr_pkg::ST_MAC: begin
				addr_q <= addr_q + prr_pkg::ADDR_BITS'(1);
				idx_q  <= idx_q + IB'(1);
			end
			prr_pkg::ST_ROUND: begin
				if (ch_q) begin
					res1_q <= sat;
				end else begin
					res0_q <= sat;
				end
				num_q <= prr_pkg::DIV_BITS'(phase_q) + prr_pkg::DIV_BITS'(down_eff);
				rem_q <= '0;
				quo_q <= '0;
			end
			prr_pkg::ST_DIV: begin
				num_q <= {num_q[prr_pkg::DIV_BITS-2:0], 1'b0};
				quo_q <= {quo_q[prr_pkg::DIV_BITS-2:0], trial_ge};
				rem_q <= trial_ge ? prr_pkg::UP_BITS'(trial - {1'b0, up_eff})
					: trial[prr_pkg::UP_BITS-1:0];
			end
			prr_pkg::ST_DECIDE: begin
				clip_q <= pad_item_q && !base_lt_real;
				last_q <= (pad_item_q && !base_lt_real) || !cond;
			end
			prr_pkg::ST_PUSH: begin
				if (out_free) begin
					m_tdata_q <= {res1_q, res0_q};
					m_tuser_q <= clip_q;
					m_tlast_q <= last_q;
				end
			end
			default: res0_q <= res0_q;
		endcase
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;
	assign m_tlast  = m_tlast_q;

`ifndef NO_ASSERTIONS
	a_finished_padding: assert property (@(posedge clk) disable iff (!arst_n)
		finished_q |-> padding_q)
		else $error("finished without padding");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= 5'(prr_pkg::MAX_RESULTS))
		else $error("result count overrun");
	a_clip_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid_q && m_tuser_q) |-> m_tlast_q)
		else $error("clip_done beat not last");
	a_mac_window: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 |-> (state_q == prr_pkg::ST_MAC || state_q == prr_pkg::ST_DRAIN))
		else $error("product outside tap walk");
`endif

endmodule

/* design/prr_ram.sv */
`timescale 1ns / 1ps
// prr_ram: generic simple dual-port RAM, one write port, one registered read port.
// No dependencies.
module prr_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* bench/testbench.sv */
`timescale 1ns / 1ps
// testbench: self-checking bench for polyphase_rational_resampler.
// A scoreboard class predicts every output beat from the accepted input beats.
// Depends on prr_pkg and the resampler RTL.
module testbench;

	localparam int WATCH_LIMIT = 100000;
	localparam int HIST = prr_pkg::HISTORY_FRAMES_DEF;
	localparam longint unsigned CMAX = 64'hFFFF_FFFF;

	typedef struct {
		prr_pkg::action_t act;
		logic [13:0] cidx;
		logic [23:0] cval;
		logic [23:0] s0;
		logic [23:0] s1;
	} item_t;

	typedef struct {
		logic [23:0] o0;
		logic [23:0] o1;
		logic        clip;
		logic        last;
	} frame_t;

	class rate_scoreboard;
		frame_t outq[$];
		int errors = 0;
		int beats_out = 0;
		int beats_in = 0;
		int coef[prr_pkg::COEF_DEPTH_DEF];
		int hist[HIST][2];
		longint unsigned seen, real_n, base;
		longint unsigned phase;
		bit padding, finished;
		longint unsigned up = 1, down = 1, reach = 34, nch = 1;

		function void set_reg(prr_pkg::cfg_reg_t r, logic [17:0] v);
			case (r)
				prr_pkg::REG_UP: up = (v[15:0] == 0) ? 1 : v[15:0];
				prr_pkg::REG_DOWN: down = (v == 0) ? 1 : v;
				prr_pkg::REG_REACH: reach = (v[10:0] == 0) ? 1 : v[10:0];
				prr_pkg::REG_CHAN: nch = (v[1:0] == 0) ? 1 : ((v[1:0] > 2) ? 2 : v[1:0]);
				default: ;
			endcase
		endfunction

		function longint unsigned sat_add(longint unsigned v, longint unsigned d);
			return (d > CMAX - v) ? CMAX : v + d;
		endfunction

		function void clear_clip();
			foreach (hist[i]) begin
				hist[i][0] = 0;
				hist[i][1] = 0;
			end
			seen = 0;
			real_n = 0;
			base = 0;
			phase = 0;
			padding = 0;
			finished = 0;
		endfunction

		function void store(int a, int b);
			hist[seen % HIST][0] = a;
			hist[seen % HIST][1] = b;
			seen = sat_add(seen, 1);
		endfunction

		function frame_t filter_point();
			frame_t f;
			longint unsigned taps, addr, total;
			longint first, idx, r;
			logic [63:0] acc;
			logic [23:0] res[2];
			taps = 2 * reach;
			first = longint'(base) - longint'(reach) + 1;
			res[0] = 0;
			res[1] = 0;
			for (int c = 0; c < nch; c++) begin
				acc = 0;
				for (longint unsigned t = 0; t < taps; t++) begin
					idx = first + longint'(t);
					addr = phase * taps + t;
					if (idx < 0 || idx >= longint'(real_n) || addr >= prr_pkg::COEF_DEPTH_DEF)
						continue;
					acc += longint'(coef[addr]) * longint'(hist[idx % HIST][c]);
				end
				acc += 64'd1 << (prr_pkg::COEF_BITS - 3);
				r = $signed(acc) >>> prr_pkg::ROUND_SHIFT;
				if (r < -(64'sd1 << 23)) r = -(64'sd1 << 23);
				if (r > (64'sd1 << 23) - 1) r = (64'sd1 << 23) - 1;
				res[c] = r[23:0];
			end
			f.o0 = res[0];
			f.o1 = res[1];
			f.clip = 0;
			f.last = 0;
			total = phase + down;
			base = sat_add(base, total / up);
			phase = total % up;
			return f;
		endfunction

		function void note_input(item_t it);
			frame_t f;
			frame_t rows[$];
			bit pass;
			int s0, s1;
			pass = (up == down);
			beats_in++;
			case (it.act)
				prr_pkg::ACT_LOAD: coef[it.cidx] = $signed(it.cval);
				prr_pkg::ACT_RESTART: clear_clip();
				prr_pkg::ACT_SAMPLE: begin
					s0 = $signed(it.s0);
					s1 = (nch > 1) ? $signed(it.s1) : 0;
					if (!(padding || finished)) begin
						store(s0, s1);
						real_n = sat_add(real_n, 1);
						if (pass) begin
							f.o0 = s0[23:0];
							f.o1 = s1[23:0];
							f.clip = 0;
							f.last = 0;
							rows.push_back(f);
						end else begin
							while (rows.size() < prr_pkg::MAX_RESULTS && base + reach < seen)
								rows.push_back(filter_point());
						end
					end
				end
				prr_pkg::ACT_PAD: begin
					if (!finished) begin
						padding = 1;
						if (pass) finished = 1;
						else begin
							store(0, 0);
							if (base >= real_n) finished = 1;
							else begin
								while (rows.size() < prr_pkg::MAX_RESULTS && base < real_n &&
									base + reach < seen) begin
									f = filter_point();
									if (base >= real_n) begin
										f.clip = 1;
										finished = 1;
										rows.push_back(f);
										break;
									end
									rows.push_back(f);
								end
							end
						end
					end
				end
				default: ;
			endcase
			if (rows.size() > 0) rows[rows.size() - 1].last = 1;
			foreach (rows[i]) outq.push_back(rows[i]);
		endfunction

		function void check(frame_t got);
			frame_t exp_f;
			beats_out++;
			if (outq.size() == 0) begin
				errors++;
				if (errors <= 10) $display("ERROR: unexpected output beat %h %h", got.o0, got.o1);
				return;
			end
			exp_f = outq.pop_front();
			if (got.o0 !== exp_f.o0 || got.o1 !== exp_f.o1 || got.clip !== exp_f.clip
				|| got.last !== exp_f.last) begin
				errors++;
				if (errors <= 10)
					$display("ERROR: beat %0d exp o0=%h o1=%h clip=%b last=%b %s%h %s%h %s%b %s%b",
						beats_out, exp_f.o0, exp_f.o1, exp_f.clip, exp_f.last,
						"got o0=", got.o0, "o1=", got.o1, "clip=", got.clip,
						"last=", got.last);
			end
		endfunction
	endclass

	logic        clk = 0;
	logic        arst_n = 0;
	logic        s_tvalid = 0;
	logic        s_tready;
	logic [87:0] s_tdata = 0;
	logic [1:0]  s_tuser = 0;
	logic        m_tvalid;
	logic        m_tready = 0;
	logic [47:0] m_tdata;
	logic        m_tuser;
	logic        m_tlast;
	logic        cfg_valid = 0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = 0;
	logic [17:0] cfg_data = 0;

	rate_scoreboard sb;
	int tx_idle_pct = 0;
	int rx_idle_pct = 0;
	int hold_asks = 0;
	int hold_seen = 0;
	int hold_left = 0;
	int quiet = 0;
	int table_n = 16;

	polyphase_rational_resampler uut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.m_tlast(m_tlast),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		frame_t f;
		if (m_tvalid && m_tready) begin
			f.o0 = m_tdata[23:0];
			f.o1 = m_tdata[47:24];
			f.clip = m_tuser;
			f.last = m_tlast;
			sb.check(f);
		end
		if (hold_asks != hold_seen) begin
			hold_seen = hold_asks;
			hold_left = 600;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 0;
		end else
			m_tready <= (rx_idle_pct == 0) || ($urandom_range(0, 99) >= rx_idle_pct);
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet > WATCH_LIMIT) begin
			$display("Timeout: no beat for %0d cycles", WATCH_LIMIT);
			$display("Some tests failed");
			$finish;
		end
	end

	function automatic logic [13:0] rnd14();
		return 14'($urandom());
	endfunction

	function automatic logic [23:0] rnd24();
		return 24'($urandom());
	endfunction

	task automatic send(item_t it);
		if (tx_idle_pct != 0 && $urandom_range(0, 99) < tx_idle_pct) begin
			s_tvalid <= 0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		s_tvalid <= 1;
		s_tuser <= it.act;
		s_tdata <= {2'b00, it.s1, it.s0, it.cval, it.cidx};
		do @(posedge clk); while (!s_tready);
		sb.note_input(it);
	endtask

	task automatic send_act(prr_pkg::action_t a, logic [13:0] ci, logic [23:0] cv,
			logic [23:0] x0, logic [23:0] x1);
		item_t it;
		it.act = a;
		it.cidx = ci;
		it.cval = cv;
		it.s0 = x0;
		it.s1 = x1;
		send(it);
	endtask

	function automatic logic [23:0] pick_sample();
		case ($urandom_range(0, 7))
			0: return 24'h800000;
			1: return 24'h7FFFFF;
			2: return 24'h000000;
			default: return rnd24();
		endcase
	endfunction

	function automatic logic [23:0] pick_coef();
		logic [15:0] small_c;
		small_c = 16'($urandom());
		if ($urandom_range(0, 1)) return rnd24();
		return {{8{small_c[15]}}, small_c};
	endfunction

	task automatic drain_out();
		s_tvalid <= 0;
		while (sb.outq.size() != 0) @(posedge clk);
		repeat (4 * (2 * sb.reach + 5) + 200) @(posedge clk);
	endtask

	task automatic write_regs(logic [15:0] u, logic [17:0] d, logic [10:0] h,
			logic [1:0] ch, int n);
		logic [17:0] vals[4];
		prr_pkg::cfg_reg_t regs[4];
		vals = '{u, d, h, ch};
		regs = '{prr_pkg::REG_UP, prr_pkg::REG_DOWN, prr_pkg::REG_REACH, prr_pkg::REG_CHAN};
		for (int i = 0; i < 4; i++) begin
			cfg_valid <= 1;
			cfg_index <= regs[i];
			cfg_data <= vals[i];
			do @(posedge clk); while (!cfg_ready);
			sb.set_reg(regs[i], vals[i]);
		end
		cfg_valid <= 0;
		table_n = n;
		for (int a = 0; a < n; a++) send_act(prr_pkg::ACT_LOAD, 14'(a), pick_coef(), 0, 0);
	endtask

	task automatic run_clip(int nsamp, int npad, bit noise, bit squeeze);
		for (int i = 0; i < nsamp; i++) begin
			if (noise && $urandom_range(0, 11) == 0)
				send_act(prr_pkg::ACT_LOAD, 14'($urandom_range(0, table_n - 1)), pick_coef(),
					0, 0);
			if (squeeze && i == nsamp / 2) hold_asks++;
			send_act(prr_pkg::ACT_SAMPLE, rnd14(), rnd24(), pick_sample(), pick_sample());
		end
		for (int i = 0; i < npad; i++)
			send_act(prr_pkg::ACT_PAD, rnd14(), rnd24(), rnd24(), rnd24());
		if (noise) begin
			send_act(prr_pkg::ACT_SAMPLE, rnd14(), rnd24(), pick_sample(), pick_sample());
			send_act(prr_pkg::ACT_PAD, 0, 0, 0, 0);
		end
		send_act(prr_pkg::ACT_RESTART, rnd14(), rnd24(), rnd24(), rnd24());
	endtask

	initial begin
		sb = new();
		sb.clear_clip();
		repeat (7) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: field extremes, every action, pad/sample corner cases
		tx_idle_pct = 38;
		rx_idle_pct = 50;
		write_regs(3, 2, 2, 2, 12);
		send_act(prr_pkg::ACT_LOAD, 14'h3FFF, 24'h800000, 0, 0);
		send_act(prr_pkg::ACT_LOAD, 14'h3FFF, 24'h7FFFFF, 0, 0);
		send_act(prr_pkg::ACT_LOAD, 0, 24'h7FFFFF, 0, 0);
		send_act(prr_pkg::ACT_LOAD, 1, 24'h800000, 0, 0);
		send_act(prr_pkg::ACT_SAMPLE, 0, 0, 24'h7FFFFF, 24'h800000);
		send_act(prr_pkg::ACT_SAMPLE, 0, 0, 24'h800000, 24'h7FFFFF);
		send_act(prr_pkg::ACT_SAMPLE, 0, 0, 24'h7FFFFF, 24'h7FFFFF);
		send_act(prr_pkg::ACT_SAMPLE, 0, 0, 24'h000000, 24'hFFFFFF);
		send_act(prr_pkg::ACT_SAMPLE, 0, 0, 24'h800000, 24'h800000);
		send_act(prr_pkg::ACT_SAMPLE, 14'h3FFF, 24'hFFFFFF, 24'h123456, 24'hFEDCBA);
		for (int i = 0; i < 6; i++) send_act(prr_pkg::ACT_PAD, 0, 0, 0, 0);
		send_act(prr_pkg::ACT_PAD, 0, 0, 0, 0);
		send_act(prr_pkg::ACT_SAMPLE, 0, 0, 24'h7FFFFF, 24'h7FFFFF);
		send_act(prr_pkg::ACT_RESTART, 0, 0, 0, 0);
		run_clip(24, 6, 1, 1);
		run_clip(12, 4, 1, 0);
		send_act(prr_pkg::ACT_SAMPLE, 0, 0, pick_sample(), pick_sample());
		drain_out();
		run_clip(8, 5, 1, 0);
		drain_out();
		write_regs(0, 2, 0, 0, 2);
		run_clip(8, 3, 1, 0);
		drain_out();

		tx_idle_pct = 50;
		rx_idle_pct = 38;
		write_regs(2, 3, 1, 1, 4);
		run_clip(12, 4, 1, 0);
		run_clip(8, 3, 1, 0);
		drain_out();
		write_regs(1, 1, 5, 3, 2);
		run_clip(8, 2, 1, 0);
		drain_out();
		write_regs(4, 3, 2, 2, 16);
		run_clip(14, 5, 1, 1);
		drain_out();

		tx_idle_pct = 0;
		rx_idle_pct = 0;
		write_regs(16'hFFFF, 18'h0FFFE, 1, 2, 2);
		run_clip(6, 2, 0, 0);
		drain_out();
		write_regs(1, 18'h3FFFF, 1, 2, 2);
		run_clip(4, 2, 1, 0);
		drain_out();

		$display("Covered %0d input beats and %0d output beats over seven register settings,",
			sb.beats_in, sb.beats_out);
		$display("with extreme factors, out-of-range phases, passthrough and zero registers.");
		if (sb.errors == 0 && sb.outq.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end
endmodule
